// ===== hdl/csim_pkg.sv =====
// Shared types and constants of the streaming cosine similarity core.
// No dependencies; every other file of the block imports this package.
package csim_pkg;

  localparam int ELEM_WIDTH       = 16;
  localparam int LEN_LOG2_DEFAULT = 12;
  // Bit positions searched for the result magnitude (0 to 32768).
  localparam int Q_BITS           = 16;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] elem_a;
    logic signed [ELEM_WIDTH-1:0] elem_b;
    logic                         last_element;
  } item_t;

  typedef struct packed {
    logic signed [15:0] similarity;
    logic               zero_magnitude;
    logic               sum_saturated;
  } result_t;

  function automatic int dot_width(input int len_log2);
    return (2 * ELEM_WIDTH + len_log2 + 1 > 62) ? 62 : 2 * ELEM_WIDTH + len_log2 + 1;
  endfunction

  function automatic int mag_width(input int len_log2);
    return (2 * ELEM_WIDTH + len_log2 > 62) ? 62 : 2 * ELEM_WIDTH + len_log2;
  endfunction

endpackage

// ===== hdl/csim_front.sv =====
// Front end: takes element pairs, keeps the three saturating running sums and
// hands the finished sums of each vector to the queue. Depends on csim_pkg.
module csim_front #(
  parameter int DW = 45,
  parameter int MW = 44
) (
  input  logic           clk,
  input  logic           rst,
  input  csim_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_stall,
  input  logic           full,
  output logic           push,
  output logic [DW+2*MW:0] push_data
);
  import csim_pkg::*;

  localparam logic signed [DW:0] DMAX = {2'b00, {(DW-1){1'b1}}};
  localparam logic signed [DW:0] DMIN = {2'b11, {(DW-1){1'b0}}};

  logic signed [DW-1:0] dot_sum;
  logic [MW-1:0]        mag_a_sum;
  logic [MW-1:0]        mag_b_sum;
  logic                 saturated_flag;

  logic signed [2*ELEM_WIDTH-1:0] pab;
  logic [2*ELEM_WIDTH-1:0]        paa;
  logic [2*ELEM_WIDTH-1:0]        pbb;
  logic signed [DW:0]             dsum;
  logic [MW:0]                    asum;
  logic [MW:0]                    bsum;
  logic signed [DW-1:0]           dot_next;
  logic [MW-1:0]                  mag_a_next;
  logic [MW-1:0]                  mag_b_next;
  logic                           sat_next;
  logic                           accept;

  assign item_stall = full;
  assign accept     = item_valid && !full;

  always_comb begin
    pab  = item.elem_a * item.elem_b;
    paa  = (2*ELEM_WIDTH)'(item.elem_a * item.elem_a);
    pbb  = (2*ELEM_WIDTH)'(item.elem_b * item.elem_b);
    dsum = (DW+1)'(dot_sum) + (DW+1)'(pab);
    asum = {1'b0, mag_a_sum} + (MW+1)'(paa);
    bsum = {1'b0, mag_b_sum} + (MW+1)'(pbb);
    sat_next = saturated_flag;
    if (dsum > DMAX) begin
      dot_next = DMAX[DW-1:0];
      sat_next = 1'b1;
    end else if (dsum < DMIN) begin
      dot_next = DMIN[DW-1:0];
      sat_next = 1'b1;
    end else begin
      dot_next = dsum[DW-1:0];
    end
    if (asum[MW]) begin
      mag_a_next = '1;
      sat_next   = 1'b1;
    end else begin
      mag_a_next = asum[MW-1:0];
    end
    if (bsum[MW]) begin
      mag_b_next = '1;
      sat_next   = 1'b1;
    end else begin
      mag_b_next = bsum[MW-1:0];
    end
  end

  assign push      = accept && item.last_element;
  assign push_data = {sat_next, dot_next, mag_a_next, mag_b_next};

  always_ff @(posedge clk) begin
    if (rst || push) begin
      dot_sum        <= '0;
      mag_a_sum      <= '0;
      mag_b_sum      <= '0;
      saturated_flag <= 1'b0;
    end else if (accept) begin
      dot_sum        <= dot_next;
      mag_a_sum      <= mag_a_next;
      mag_b_sum      <= mag_b_next;
      saturated_flag <= sat_next;
    end
  end

endmodule

// ===== hdl/csim_queue.sv =====
// Two-entry queue of finished vector sums between the front and back ends.
// Depends on csim_pkg only by convention of the block.
module csim_queue #(
  parameter int WIDTH = 134
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             entry_valid,
  output logic [WIDTH-1:0] entry
);
  import csim_pkg::*;

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full        = (count == 2'd2);
  assign entry_valid = (count != 2'd0);
  assign entry       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/csim_back.sv =====
// Back end: forms ma*mb and dot^2 by shift and add, then finds the rounded
// cosine bit by bit, and holds the result in an output register. Uses csim_pkg.
module csim_back #(
  parameter int DW = 45,
  parameter int MW = 44
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             entry_valid,
  input  logic [DW+2*MW:0] entry,
  output logic             pop,
  output csim_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_stall
);
  import csim_pkg::*;

  localparam int CW  = 2 * MW + 35;
  localparam int CNW = (DW > 1) ? $clog2(DW) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_SETUP = 6'b000100,
    S_TRY   = 6'b001000,
    S_CMP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [CW-1:0]        mcand_p;
  logic [DW-1:0]        mplier_p;
  logic [CW-1:0]        mcand_r;
  logic [DW-1:0]        mplier_r;
  logic [CW-1:0]        p_acc;
  logic [CW-1:0]        r_acc;
  logic [CNW-1:0]       cnt;
  logic                 neg;
  logic                 zero;
  logic                 sat;
  logic [CW-1:0]        pk2;
  logic signed [CW-1:0] t1;
  logic [CW-1:0]        t2;
  logic [CW-1:0]        trial;
  logic [Q_BITS-1:0]    q;
  logic [3:0]           bit_idx;

  logic signed [DW-1:0] e_dot;
  logic [MW-1:0]        e_ma;
  logic [MW-1:0]        e_mb;
  logic [DW-1:0]        e_adot;
  logic signed [CW-1:0] t1_acc;
  logic                 out_free;
  logic signed [15:0]   sim;

  assign e_mb   = entry[MW-1:0];
  assign e_ma   = entry[2*MW-1:MW];
  assign e_dot  = entry[DW+2*MW-1:2*MW];
  assign e_adot = e_dot[DW-1] ? $unsigned(-e_dot) : $unsigned(e_dot);
  assign t1_acc = t1 + $signed(t2 << 1);

  assign pop      = (state == S_IDLE) && entry_valid;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    if (zero) begin
      sim = '0;
    end else if (neg) begin
      sim = $signed(-q);
    end else if (q[Q_BITS-1]) begin
      sim = 16'sh7fff;
    end else begin
      sim = $signed(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (entry_valid) begin
            state <= (e_ma == '0 || e_mb == '0) ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          if (cnt == CNW'(DW - 1)) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: state <= S_TRY;
        S_TRY:   state <= S_CMP;
        S_CMP: begin
          if ((trial <= r_acc && bit_idx == 4'(Q_BITS - 1)) || bit_idx == 4'd0) begin
            state <= S_DONE;
          end else begin
            state <= S_TRY;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        mcand_p  <= CW'(e_ma);
        mplier_p <= DW'(e_mb);
        mcand_r  <= CW'(e_adot) << 32;
        mplier_r <= e_adot;
        p_acc    <= '0;
        r_acc    <= '0;
        cnt      <= '0;
        neg      <= e_dot[DW-1];
        zero     <= (e_ma == '0 || e_mb == '0);
        sat      <= entry[DW+2*MW];
        q        <= '0;
      end
      S_MUL: begin
        if (mplier_p[0]) begin
          p_acc <= p_acc + mcand_p;
        end
        if (mplier_r[0]) begin
          r_acc <= r_acc + mcand_r;
        end
        mcand_p  <= mcand_p << 1;
        mplier_p <= mplier_p >> 1;
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
        cnt      <= cnt + CNW'(1);
      end
      S_SETUP: begin
        // Start from q = 0, which stands for the odd factor k = -1.
        pk2     <= p_acc;
        t1      <= -$signed(p_acc << (Q_BITS + 1));
        t2      <= p_acc << (2 * Q_BITS);
        bit_idx <= 4'(Q_BITS - 1);
      end
      S_TRY: begin
        trial <= pk2 + $unsigned(t1) + t2;
      end
      S_CMP: begin
        if (trial <= r_acc) begin
          q[bit_idx] <= 1'b1;
          pk2        <= trial;
          t1         <= t1_acc >>> 1;
        end else begin
          t1 <= t1 >>> 1;
        end
        t2      <= t2 >> 2;
        bit_idx <= bit_idx - 4'd1;
      end
      S_DONE: begin
        if (out_free) begin
          result.similarity     <= sim;
          result.zero_magnitude <= zero;
          result.sum_saturated  <= sat;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/cosine_similarity_stream_core.sv =====
// Top level of the streaming cosine similarity core: front end, sum queue and
// back end. Depends on csim_pkg, csim_front, csim_queue and csim_back.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  item     | item_valid / item_stall   | elem_a, elem_b, last_element
//  result   | result_valid / result_stall | similarity, zero_magnitude, sum_saturated
//
// One element pair is taken every cycle while the queue is not full; the front
// end's multiply-accumulate sets that rate. The back end takes one vector at a
// time: it forms its products by shift and add, then runs the bit-by-bit search;
// a vector with a zero magnitude skips both. Two finished vectors may wait in
// the queue; item_stall rises only when the queue is full.
// Synchronous reset clears all sums, the queue and result_valid, not the result fields.
module cosine_similarity_stream_core #(
  parameter int LEN_LOG2 = csim_pkg::LEN_LOG2_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  csim_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_stall,
  output csim_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_stall
);
  import csim_pkg::*;

  localparam int DW = dot_width(LEN_LOG2);
  localparam int MW = mag_width(LEN_LOG2);
  localparam int QW = DW + 2 * MW + 1;

  logic          full;
  logic          push;
  logic [QW-1:0] push_data;
  logic          pop;
  logic          entry_valid;
  logic [QW-1:0] entry;

  csim_front #(.DW(DW), .MW(MW)) u_front (
    .clk(clk), .rst(rst), .item(item), .item_valid(item_valid),
    .item_stall(item_stall), .full(full), .push(push), .push_data(push_data)
  );

  csim_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(pop),
    .full(full), .entry_valid(entry_valid), .entry(entry)
  );

  csim_back #(.DW(DW), .MW(MW)) u_back (
    .clk(clk), .rst(rst), .entry_valid(entry_valid), .entry(entry), .pop(pop),
    .result(result), .result_valid(result_valid), .result_stall(result_stall)
  );

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_zero_sim: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.zero_magnitude |-> result.similarity == 16'sd0)
    else $error("zero magnitude with non-zero similarity");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> entry_valid)
    else $error("queue popped while empty");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the streaming cosine similarity core.
// Depends on csim_pkg and cosine_similarity_stream_core; carries its own predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csim_pkg::*;

  localparam int DOT_W = dot_width(LEN_LOG2_DEFAULT);
  localparam int MAG_W = mag_width(LEN_LOG2_DEFAULT);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1530;
  localparam int SAT_LEN = 200;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  item_t   item = '0;
  logic    item_valid = 1'b0;
  logic    item_stall;
  result_t result;
  logic    result_valid;
  logic    result_stall = 1'b0;

  cosine_similarity_stream_core dut (
    .clk(clk), .rst(rst), .item(item), .item_valid(item_valid),
    .item_stall(item_stall), .result(result), .result_valid(result_valid),
    .result_stall(result_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Running sums of the predictor.
  longint  dot_acc;
  longint  mag_a_acc;
  longint  mag_b_acc;
  bit      sat_seen;
  result_t cos_expected[$];
  int      errors = 0;
  int      cycles = 0;
  bit      quiet = 1'b0;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    bit                 last;
    bit                 typed;
    result_t            res;
  } row_t;

  function automatic int unsigned cos_q(longint unsigned adot, longint unsigned ma,
                                        longint unsigned mb);
    logic [255:0] prod, rhs, lhs;
    int unsigned lo, hi, mid;
    longint unsigned k;
    lo = 0;
    hi = 32768;
    prod = 256'(ma) * 256'(mb);
    rhs = (256'(adot) * 256'(adot)) << 32;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k = 2 * longint'(mid) - 1;
      lhs = prod * 256'(k * k);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Accumulates one pair; returns 1 and the result when the pair closes a vector.
  function automatic bit cos_accumulate(item_t it, output result_t r);
    longint dmax, dmin, mmax, d, ma, mb, a, b;
    int unsigned q;
    dmax = (64'sd1 <<< (DOT_W - 1)) - 1;
    dmin = -dmax - 1;
    mmax = (64'sd1 <<< MAG_W) - 1;
    a = it.elem_a;
    b = it.elem_b;
    d = dot_acc + a * b;
    ma = mag_a_acc + a * a;
    mb = mag_b_acc + b * b;
    if (d > dmax) begin d = dmax; sat_seen = 1'b1; end
    if (d < dmin) begin d = dmin; sat_seen = 1'b1; end
    if (ma > mmax) begin ma = mmax; sat_seen = 1'b1; end
    if (mb > mmax) begin mb = mmax; sat_seen = 1'b1; end
    dot_acc = d;
    mag_a_acc = ma;
    mag_b_acc = mb;
    r = '0;
    if (!it.last_element) return 1'b0;
    if (ma == 0 || mb == 0) begin
      r.zero_magnitude = 1'b1;
    end else begin
      q = cos_q(d < 0 ? -d : d, ma, mb);
      if (d < 0) r.similarity = 16'(-int'(q));
      else r.similarity = (q > 32767) ? 16'sd32767 : 16'(q);
    end
    r.sum_saturated = sat_seen;
    dot_acc = 0;
    mag_a_acc = 0;
    mag_b_acc = 0;
    sat_seen = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Presents one beat, waits for acceptance and records the prediction.
  task automatic send_pair(item_t it, bit typed = 1'b0, result_t typed_res = '0);
    result_t r;
    while (!quiet && $urandom_range(99) < 29) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (cos_accumulate(it, r)) cos_expected.push_back(typed ? typed_res : r);
  endtask

  function automatic logic signed [15:0] pick_elem();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3: return 16'($signed($urandom_range(15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= quiet ? 1'b0 : ($urandom_range(99) < 29);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (cos_expected.size() == 0) begin
        report_mismatch("unexpected result, similarity", result.similarity, 0);
      end else begin
        want = cos_expected.pop_front();
        if (result.similarity !== want.similarity)
          report_mismatch("similarity", result.similarity, want.similarity);
        if (result.zero_magnitude !== want.zero_magnitude)
          report_mismatch("zero_magnitude", result.zero_magnitude, want.zero_magnitude);
        if (result.sum_saturated !== want.sum_saturated)
          report_mismatch("sum_saturated", result.sum_saturated, want.sum_saturated);
      end
    end
  end

  initial begin
    row_t    rows[$];
    item_t   it;
    result_t none;
    int      sent, len, kind, wait_cycles;
    bit      drained;
    none = '0;
    drained = 1'b0;
    dot_acc = 0;
    mag_a_acc = 0;
    mag_b_acc = 0;
    sat_seen = 1'b0;
    // Single-pair vectors have a cosine of exactly plus or minus one, or no magnitude; short multi-pair vectors follow.
    rows.push_back('{16'sd0, 16'sd0, 1, 1, '{16'sd0, 1'b1, 1'b0}});
    rows.push_back('{16'sd0, 16'sd5, 1, 1, '{16'sd0, 1'b1, 1'b0}});
    rows.push_back('{16'sh8000, 16'sd0, 1, 1, '{16'sd0, 1'b1, 1'b0}});
    rows.push_back('{16'sh7fff, 16'sh7fff, 1, 1, '{16'sd32767, 1'b0, 1'b0}});
    rows.push_back('{16'sh8000, 16'sh8000, 1, 1, '{16'sd32767, 1'b0, 1'b0}});
    rows.push_back('{16'sh8000, 16'sh7fff, 1, 1, '{16'sh8000, 1'b0, 1'b0}});
    rows.push_back('{16'sd1, -16'sd1, 1, 1, '{16'sh8000, 1'b0, 1'b0}});
    rows.push_back('{16'sd3, 16'sd4, 0, 0, none});
    rows.push_back('{16'sd4, -16'sd3, 1, 0, none});
    rows.push_back('{16'sh7fff, 16'sd1, 0, 0, none});
    rows.push_back('{16'sd1, 16'sh7fff, 1, 0, none});
    rows.push_back('{16'sh8000, 16'sh7fff, 0, 0, none});
    rows.push_back('{16'sh7fff, 16'sh8000, 0, 0, none});
    rows.push_back('{-16'sd2, 16'sd9, 1, 0, none});
    rows.push_back('{16'sd0, 16'sd0, 0, 0, none});
    rows.push_back('{16'sd0, 16'sd7, 1, 1, '{16'sd0, 1'b1, 1'b0}});
    rows.push_back('{16'sd100, 16'sd101, 0, 0, none});
    rows.push_back('{16'sd99, 16'sd100, 1, 0, none});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      it.elem_a = rows[i].a;
      it.elem_b = rows[i].b;
      it.last_element = rows[i].last;
      send_pair(it, rows[i].typed, rows[i].res);
    end

    // Long vector of extreme elements, sent back to back with no idling.
    quiet = 1'b1;
    for (int i = 0; i < SAT_LEN; i++) begin
      it.elem_a = 16'sh8000;
      it.elem_b = (i % 2) ? 16'sh8000 : 16'sh7fff;
      it.last_element = (i == SAT_LEN - 1);
      send_pair(it);
    end
    quiet = 1'b0;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent > 600 && sent < 800) quiet = 1'b1;
      else quiet = 1'b0;
      if (sent > 1000 && !drained) begin
        drained = 1'b1;
        item_valid <= 1'b0;
        while (cos_expected.size() != 0) @(posedge clk);
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
      kind = $urandom_range(9);
      for (int j = 0; j < len; j++) begin
        case (kind)
          0: begin it.elem_a = 16'sd0; it.elem_b = pick_elem(); end
          1: begin it.elem_a = pick_elem(); it.elem_b = pick_elem(); end
          2: begin it.elem_a = pick_elem(); it.elem_b = it.elem_a; end
          3: begin it.elem_a = pick_elem(); it.elem_b = -it.elem_a; end
          default: begin it.elem_a = 16'($urandom); it.elem_b = 16'($urandom); end
        endcase
        it.last_element = (j == len - 1);
        send_pair(it);
        sent++;
      end
    end
    item_valid <= 1'b0;

    wait_cycles = 0;
    while (cos_expected.size() != 0) @(posedge clk);
    while (wait_cycles < 300) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
